### src/ppgwar_pkg.sv
// Shared types and constants for the optical-sensor window average reporter.
package ppgwar_pkg;

  localparam int SAMPLE_W       = 24;
  localparam int RESULT_W       = 22;
  localparam int NUM_REPORTED   = 3;
  localparam int MODE_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int DISCARD_W      = 8;
  localparam int DISCARD_RESET  = 30;
  localparam int GAIN_W         = 14;
  localparam int GAIN_CROSSTALK = 4500;
  localparam int GAIN_LEAKAGE   = 450;
  localparam int MIDSCALE       = 1 << 23;
  localparam int FRAC_SHIFT     = 15;
  localparam int ROUND_BIAS     = 1 << 14;
  localparam int CELL_STAGES    = 7;
  localparam int OUT_DEPTH      = 4;
  localparam int OUT_PTR_W      = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W      = $clog2(OUT_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF       = 2'd0,
    MODE_CROSSTALK = 2'd1,
    MODE_LEAKAGE   = 2'd2,
    MODE_NOISE     = 2'd3
  } run_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 2'd0,
    REG_DISCARD = 2'd1
  } cfg_reg_e;

  // control word that travels down the cell chain with each token
  typedef struct packed {
    logic valid;
    logic clear;   // empty the running sum
    logic win;     // sample enters the window
    logic evict;   // window full: oldest entry leaves the sum
    logic report;  // cells fill in their scaled mean
    logic kind;    // 0 crosstalk, 1 leakage
  } ctl_t;

  typedef struct packed {
    logic                                   kind;
    logic [NUM_REPORTED-1:0][RESULT_W-1:0]  res;
  } out_item_t;

endpackage

### src/ppgwar_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module ppgwar_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/ppgwar_cell.sv
// One channel cell: window memory, running sum and mean scaling pipeline.
module ppgwar_cell import ppgwar_pkg::*; #(
  parameter int IDX        = 0,
  parameter int CHANNELS   = 3,
  parameter int WINDOW_LEN = 80
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  ctl_t                                    ctl_i,
  input  logic [$clog2(WINDOW_LEN)-1:0]           slot_i,
  input  logic [CHANNELS-1:0][SAMPLE_W-1:0]       smp_i,
  input  logic [CHANNELS-1:0][RESULT_W-1:0]       res_i,
  output ctl_t                                    ctl_o,
  output logic [$clog2(WINDOW_LEN)-1:0]           slot_o,
  output logic [CHANNELS-1:0][SAMPLE_W-1:0]       smp_o,
  output logic [CHANNELS-1:0][RESULT_W-1:0]       res_o
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int PROD_W = 2 * SUM_W;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int SCL_W  = DIFF_W + GAIN_W;
  localparam int NST    = CELL_STAGES;
  // floor(2^SUM_W / WINDOW_LEN); quotient estimate is low by at most one
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / WINDOW_LEN);
  localparam logic [SUM_W-1:0] WLEN  = SUM_W'(WINDOW_LEN);

  ctl_t                              ctl_q  [NST];
  logic [SLOT_W-1:0]                 slot_q [NST];
  logic [CHANNELS-1:0][SAMPLE_W-1:0] smp_q  [NST];
  logic [CHANNELS-1:0][RESULT_W-1:0] res_q  [NST];
  logic [CHANNELS-1:0][RESULT_W-1:0] res_last_d;

  logic [SAMPLE_W-1:0] rd_data;
  logic                ram_we;

  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SUM_W-1:0]    b_sum_q;
  logic [PROD_W-1:0]   c_prod_q;
  logic [SUM_W-1:0]    c_sum_q;
  logic [SAMPLE_W-1:0] d_quo_q, d_quo_d;
  logic [SUM_W-1:0]    d_qw_q, d_sum_q, rem;
  logic [SAMPLE_W-1:0] mean;
  logic signed [DIFF_W-1:0] e_diff_q, e_diff_d;
  logic signed [GAIN_W-1:0] gain;
  logic signed [SCL_W-1:0]  f_prod_q, f_prod_d, rnd;

  assign ram_we = ctl_q[0].valid & ctl_q[0].win;

  ppgwar_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q[0]),
    .wdata_i (smp_q[0][IDX]),
    .raddr_i (slot_i),
    .rdata_o (rd_data)
  );

  // running sum; the evicted entry comes from the registered read issued when the token entered the cell
  always_comb begin
    sum_d = sum_q;
    if (ctl_q[0].valid) begin
      if (ctl_q[0].clear) begin
        sum_d = '0;
      end else if (ctl_q[0].win) begin
        sum_d = sum_q - (ctl_q[0].evict ? SUM_W'(rd_data) : '0)
                + SUM_W'(smp_q[0][IDX]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // mean = floor(sum / WINDOW_LEN) by reciprocal, then one correction
  assign d_quo_d = c_prod_q[SUM_W +: SAMPLE_W];
  assign rem     = d_sum_q - d_qw_q;
  assign mean    = d_quo_q + SAMPLE_W'(rem >= WLEN);
  assign e_diff_d = $signed({1'b0, mean}) - $signed(DIFF_W'(MIDSCALE));
  assign gain     = ctl_q[4].kind ? GAIN_W'(GAIN_LEAKAGE) : GAIN_W'(GAIN_CROSSTALK);
  assign f_prod_d = e_diff_q * gain;
  assign rnd      = f_prod_q + SCL_W'(ROUND_BIAS);

  always_comb begin
    res_last_d = res_q[NST-2];
    if (ctl_q[NST-2].report) begin
      res_last_d[IDX] = rnd[FRAC_SHIFT +: RESULT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    b_sum_q  <= sum_d;
    c_prod_q <= PROD_W'(b_sum_q) * PROD_W'(RECIP);
    c_sum_q  <= b_sum_q;
    d_quo_q  <= d_quo_d;
    d_qw_q   <= SUM_W'(d_quo_d) * WLEN;
    d_sum_q  <= c_sum_q;
    e_diff_q <= e_diff_d;
    f_prod_q <= f_prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        ctl_q[k] <= '0;
      end
    end else begin
      ctl_q[0] <= ctl_i;
      for (int k = 1; k < NST; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_i;
    smp_q[0]  <= smp_i;
    res_q[0]  <= res_i;
    for (int k = 1; k < NST; k++) begin
      slot_q[k] <= slot_q[k-1];
      smp_q[k]  <= smp_q[k-1];
    end
    for (int k = 1; k < NST - 1; k++) begin
      res_q[k] <= res_q[k-1];
    end
    res_q[NST-1] <= res_last_d;
  end

  assign ctl_o  = ctl_q[NST-1];
  assign slot_o = slot_q[NST-1];
  assign smp_o  = smp_q[NST-1];
  assign res_o  = res_q[NST-1];

endmodule

### src/ppg_window_average_test_reporter.sv
// Top level of the optical-sensor window average test reporter.
//
// Takes one frame per cycle on the slave stream (tlast marks the end of a
// batch) and emits scaled window means on the master stream. Frame control
// (discard count, ring slot, fill level, report divider) is resolved in the
// cycle of acceptance; the frame then walks a chain of one cell per channel,
// each cell a seven-stage pipe doing a window-memory read-modify-write and
// mean scaling; a report leaves the end of the chain into the output queue.
// Input is taken every cycle, but not during a config write, while fewer than
// four reports are in flight or queued in the four-entry output queue; with
// a stalled output the input stops once that queue is committed. A mode write
// empties the window: the clear travels the chain ahead of later frames, and
// the window memory is never swept since entries are read only after a write.
module ppg_window_average_test_reporter import ppgwar_pkg::*; #(
  parameter int CHANNELS     = 3,
  parameter int WINDOW_LEN   = 80,
  parameter int REPORT_EVERY = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [71:0]           s_axis_tdata,   // sample_green, sample_ir, sample_red
  input  logic                  s_axis_tlast,   // batch_end
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [71:0]           m_axis_tdata,   // pad, result_green, result_ir, result_red
  output logic                  m_axis_tuser,   // report_kind
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int DIV_W  = (REPORT_EVERY > 1) ? $clog2(REPORT_EVERY) : 1;

  run_mode_e            mode_q, mode_d;
  logic [DISCARD_W-1:0] discard_cfg_q, discard_cfg_d;
  logic [DISCARD_W-1:0] discard_left_q, discard_left_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [DIV_W-1:0]     div_q, div_d;
  logic [OUT_CNT_W-1:0] resv_q, resv_d;

  ctl_t                              tok_ctl_q, tok_ctl_d;
  logic [SLOT_W-1:0]                 tok_slot_q;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] tok_smp_q, tok_smp_d;
  logic [NUM_REPORTED-1:0][SAMPLE_W-1:0] in_smp;

  logic in_acc, out_pop, push;

  ctl_t                              ch_ctl  [CHANNELS+1];
  logic [SLOT_W-1:0]                 ch_slot [CHANNELS+1];
  logic [CHANNELS-1:0][SAMPLE_W-1:0] ch_smp  [CHANNELS+1];
  logic [CHANNELS-1:0][RESULT_W-1:0] ch_res  [CHANNELS+1];

  out_item_t             fifo_q [OUT_DEPTH];
  out_item_t             push_item;
  logic [OUT_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0]  cnt_q;

  assign in_smp = s_axis_tdata[NUM_REPORTED*SAMPLE_W-1:0];

  for (genvar c = 0; c < CHANNELS; c++) begin : g_smp
    if (c < NUM_REPORTED) begin : g_real
      assign tok_smp_d[c] = in_smp[c];
    end else begin : g_zero
      assign tok_smp_d[c] = '0;
    end
  end

  assign s_axis_tready = (resv_q < OUT_CNT_W'(OUT_DEPTH)) && !cfg_we_i;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_pop       = m_axis_tvalid && m_axis_tready;

  always_comb begin
    mode_d         = mode_q;
    discard_cfg_d  = discard_cfg_q;
    discard_left_d = discard_left_q;
    slot_d         = slot_q;
    fill_d         = fill_q;
    div_d          = div_q;
    tok_ctl_d      = '0;

    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MODE: begin
          mode_d          = run_mode_e'(cfg_data_i[MODE_W-1:0]);
          slot_d          = '0;
          fill_d          = '0;
          discard_left_d  = discard_cfg_q;
          tok_ctl_d.valid = 1'b1;
          tok_ctl_d.clear = 1'b1;
        end
        REG_DISCARD: discard_cfg_d = cfg_data_i[DISCARD_W-1:0];
        default: ;
      endcase
    end else if (in_acc && mode_q != MODE_OFF) begin
      if (discard_left_q != '0) begin
        discard_left_d = discard_left_q - 1'b1;
      end else begin
        tok_ctl_d.win   = 1'b1;
        tok_ctl_d.evict = (fill_q == FILL_W'(WINDOW_LEN));
        slot_d = (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
        if (fill_q != FILL_W'(WINDOW_LEN)) begin
          fill_d = fill_q + 1'b1;
        end
      end
      // divider counts batch ends with a full window, noise mode included
      if (s_axis_tlast && fill_d == FILL_W'(WINDOW_LEN)) begin
        div_d = (div_q == DIV_W'(REPORT_EVERY - 1)) ? '0 : div_q + 1'b1;
        tok_ctl_d.report = (div_q == '0) && (mode_q != MODE_NOISE);
      end
      tok_ctl_d.kind  = (mode_q == MODE_LEAKAGE);
      tok_ctl_d.valid = tok_ctl_d.win | tok_ctl_d.report;
    end
  end

  // reports committed to the output queue, in flight or waiting
  assign resv_d = resv_q + OUT_CNT_W'(tok_ctl_d.report) - OUT_CNT_W'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_OFF;
      discard_cfg_q  <= DISCARD_W'(DISCARD_RESET);
      discard_left_q <= DISCARD_W'(DISCARD_RESET);
      slot_q         <= '0;
      fill_q         <= '0;
      div_q          <= '0;
      resv_q         <= '0;
      tok_ctl_q      <= '0;
    end else begin
      mode_q         <= mode_d;
      discard_cfg_q  <= discard_cfg_d;
      discard_left_q <= discard_left_d;
      slot_q         <= slot_d;
      fill_q         <= fill_d;
      div_q          <= div_d;
      resv_q         <= resv_d;
      tok_ctl_q      <= tok_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_slot_q <= slot_q;
    tok_smp_q  <= tok_smp_d;
  end

  assign ch_ctl[0]  = tok_ctl_q;
  assign ch_slot[0] = tok_slot_q;
  assign ch_smp[0]  = tok_smp_q;
  assign ch_res[0]  = '0;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_cell
    ppgwar_cell #(
      .IDX        (c),
      .CHANNELS   (CHANNELS),
      .WINDOW_LEN (WINDOW_LEN)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ch_ctl[c]),
      .slot_i (ch_slot[c]),
      .smp_i  (ch_smp[c]),
      .res_i  (ch_res[c]),
      .ctl_o  (ch_ctl[c+1]),
      .slot_o (ch_slot[c+1]),
      .smp_o  (ch_smp[c+1]),
      .res_o  (ch_res[c+1])
    );
  end

  assign push           = ch_ctl[CHANNELS].valid && ch_ctl[CHANNELS].report;
  assign push_item.kind = ch_ctl[CHANNELS].kind;

  for (genvar r = 0; r < NUM_REPORTED; r++) begin : g_res
    if (r < CHANNELS) begin : g_real
      assign push_item.res[r] = ch_res[CHANNELS][r];
    end else begin : g_zero
      assign push_item.res[r] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (out_pop) begin
        rd_ptr_q <= (rd_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + OUT_CNT_W'(push) - OUT_CNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tuser  = fifo_q[rd_ptr_q].kind;
  assign m_axis_tdata  = {6'b0, fifo_q[rd_ptr_q].res};

  // output queue never takes an item it has no room for
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !out_pop) |-> (cnt_q < OUT_CNT_W'(OUT_DEPTH)))
    else $error("output queue overflow");

  // every queued report was reserved at frame acceptance
  a_resv_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resv_q >= cnt_q)
    else $error("report reservation below queue fill");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= FILL_W'(WINDOW_LEN)) && (slot_q <= SLOT_W'(WINDOW_LEN - 1)))
    else $error("window fill or slot out of range");

  // a mode write restarts the window on the next cycle
  a_clear_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == REG_MODE) |=> (fill_q == '0 && slot_q == '0))
    else $error("mode write did not empty the window");

endmodule
